@@ rtl/core/bsra_pkg.sv @@
// shared types and constants of the bitmap slot run allocator
package bsra_pkg;

  // page geometry: the bitmap is kept as rows of slot bits
  localparam int SLOTS     = 256;
  localparam int RUN_LIMIT = 64;
  localparam int ROW_W     = 16;
  localparam int ROWS      = SLOTS / ROW_W;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int COL_W     = $clog2(ROW_W);

  // field widths
  localparam int CNT_W      = 9;
  localparam int IDX_W      = 8;
  localparam int LEN_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0] SLOTS_RESET   = 9'd256;
  localparam logic [LEN_W-1:0] MAX_RUN_RESET = 7'd16;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN      = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;     // latch the request and pick the first row
    logic       scan;     // look for the first clear slot in the current row
    logic       ext;      // extend the run from bit 0 of the current row
    logic       clr;      // clear the freed slots of the current row
    logic       adv;      // move to the next row
    logic       finish;   // update counters and issue the result
    logic [1:0] status;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic found;      // current row holds a clear slot below the limit
    logic cont;       // run reaches the row end and may go on in the next row
    logic last_row;   // no further row holds usable slots
    logic range_bad;  // free range passes the slots in use
    logic zero_len;   // free of zero length
    logic free_last;  // current row is the last row of the free range
  } dp_stat_t;

endpackage

@@ rtl/core/bsra_ctrl.sv @@
// request sequencer of the bitmap slot run allocator
module bsra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_opcode,
  input  bsra_pkg::dp_stat_t stat,
  output bsra_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXT,
    S_FREE,
    S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] stat_r, stat_nxt;

  // state and result status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stat_r  <= bsra_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
    end
  end

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    stat_nxt  = stat_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          stat_nxt  = bsra_pkg::ST_OK;
          state_nxt = (in_opcode == bsra_pkg::OP_FREE) ? S_FREE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.found) begin
          if (stat.cont) begin
            cmd.adv   = 1'b1;
            state_nxt = S_EXT;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (stat.last_row) begin
          stat_nxt  = bsra_pkg::ST_NO_FREE;
          state_nxt = S_DONE;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      S_EXT: begin
        cmd.ext = 1'b1;
        if (stat.cont) begin
          cmd.adv = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FREE: begin
        if (stat.range_bad) begin
          stat_nxt  = bsra_pkg::ST_RANGE;
          state_nxt = S_DONE;
        end else if (stat.zero_len) begin
          state_nxt = S_DONE;
        end else begin
          cmd.clr = 1'b1;
          if (stat.free_last) begin
            state_nxt = S_DONE;
          end else begin
            cmd.adv = 1'b1;
          end
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        cmd.status = stat_r;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ rtl/core/bsra_dpath.sv @@
// bitmap memory, row logic, counters and configuration of the slot run allocator
module bsra_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bsra_pkg::dp_cmd_t                   cmd,
  output bsra_pkg::dp_stat_t                  stat,
  input  logic                                in_opcode,
  input  logic [bsra_pkg::IDX_W-1:0]          in_run_start,
  input  logic [bsra_pkg::LEN_W-1:0]          in_run_length,
  input  logic                                cfg_we,
  input  logic [bsra_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [bsra_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [bsra_pkg::IDX_W-1:0]          out_grant_start,
  output logic [bsra_pkg::LEN_W-1:0]          out_grant_length,
  output logic [bsra_pkg::CNT_W-1:0]          out_used_count,
  output logic [bsra_pkg::CNT_W-1:0]          out_peak_count
);

  localparam int RW  = bsra_pkg::ROW_W;
  localparam int AW  = bsra_pkg::ROW_AW;
  localparam int CW  = bsra_pkg::COL_W;
  localparam int NW  = bsra_pkg::CNT_W;
  localparam int LW  = bsra_pkg::LEN_W;
  localparam int IW  = bsra_pkg::IDX_W;

  // configuration
  logic [NW-1:0] slots_r;
  logic [LW-1:0] maxrun_r;

  // request context
  logic          op_r;
  logic [NW-1:0] lo_r, hi_r;
  logic [LW-1:0] len_r;
  logic [AW-1:0] row_r, row_nxt;
  logic [IW-1:0] first_r;
  logic [LW-1:0] run_r;
  logic [NW-1:0] used_r, peak_r;

  // bitmap rows
  logic [RW-1:0] mem [bsra_pkg::ROWS];
  logic [bsra_pkg::ROWS-1:0] row_vld_r;
  logic [RW-1:0] rd_word_r;
  logic          rd_vld_r;
  logic [RW-1:0] word;
  logic          wr_en;
  logic [RW-1:0] wr_word;

  // row evaluation
  logic [NW-1:0] n_eff;
  logic [LW-1:0] limit;
  logic [NW-1:0] base;
  logic [RW-1:0] free_bits;
  logic [CW-1:0] p;
  logic [CW-1:0] s;
  logic [RW-1:0] shifted;
  logic [CW:0]   cnt;
  logic [LW-1:0] budget;
  logic [CW:0]   take;
  logic [CW:0]   end_pos;
  logic [LW-1:0] run_new;
  logic [RW-1:0] set_mask, clr_mask;
  logic [NW-1:0] hi_m1;

  // result arithmetic
  logic [NW:0]   used_sum;
  logic [NW-1:0] used_add, used_sub, used_new, peak_new;

  // effective limits
  assign n_eff = (slots_r > bsra_pkg::SLOTS_RESET) ? bsra_pkg::SLOTS_RESET : slots_r;
  always_comb begin
    if (maxrun_r == '0) begin
      limit = LW'(1);
    end else if (maxrun_r > LW'(bsra_pkg::RUN_LIMIT)) begin
      limit = LW'(bsra_pkg::RUN_LIMIT);
    end else begin
      limit = maxrun_r;
    end
  end

  // row pointer steering, also the memory read address
  always_comb begin
    row_nxt = row_r;
    if (cmd.load) begin
      row_nxt = (in_opcode == bsra_pkg::OP_FREE) ? in_run_start[IW-1:CW] : '0;
    end else if (cmd.adv) begin
      row_nxt = row_r + AW'(1);
    end
  end

  // rows never written read as clear
  assign word = rd_vld_r ? rd_word_r : '0;
  assign base = {1'b0, row_r, {CW{1'b0}}};

  // usable clear slots of the row and the first of them
  always_comb begin
    p = '0;
    for (int k = 0; k < RW; k++) begin
      free_bits[k] = ~word[k] && ((base + NW'(k)) < n_eff);
    end
    for (int k = RW - 1; k >= 0; k--) begin
      if (free_bits[k]) begin
        p = CW'(k);
      end
    end
  end

  // length of the clear run from the start bit, cut to the remaining budget
  always_comb begin
    s       = cmd.scan ? p : '0;
    shifted = free_bits >> s;
    cnt     = (CW + 1)'(RW);
    for (int k = RW - 1; k >= 0; k--) begin
      if (!shifted[k]) begin
        cnt = (CW + 1)'(k);
      end
    end
    budget  = limit - run_r;
    take    = (budget > LW'(cnt)) ? cnt : budget[CW:0];
    end_pos = {1'b0, s} + take;
    run_new = run_r + LW'(take);
  end

  // bit masks for setting a run and clearing a freed range
  always_comb begin
    for (int k = 0; k < RW; k++) begin
      set_mask[k] = ((CW + 1)'(k) >= {1'b0, s}) && ((CW + 1)'(k) < end_pos);
      clr_mask[k] = ((base + NW'(k)) >= lo_r) && ((base + NW'(k)) < hi_r);
    end
  end

  assign hi_m1 = hi_r - NW'(1);

  // status back to the controller
  always_comb begin
    stat.found     = |free_bits;
    stat.cont      = (end_pos == (CW + 1)'(RW)) && (run_new < limit) &&
                     (row_r != AW'(bsra_pkg::ROWS - 1)) && ((base + NW'(RW)) < n_eff);
    stat.last_row  = (row_r == AW'(bsra_pkg::ROWS - 1)) || ((base + NW'(RW)) >= n_eff);
    stat.range_bad = hi_r > n_eff;
    stat.zero_len  = (len_r == '0);
    stat.free_last = (row_r == hi_m1[IW-1:CW]);
  end

  // row write back
  always_comb begin
    wr_en   = (cmd.scan && stat.found) || cmd.ext || cmd.clr;
    wr_word = cmd.clr ? (word & ~clr_mask) : (word | set_mask);
  end

  // bitmap memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    rd_word_r <= mem[row_nxt];
    if (wr_en) begin
      mem[row_r] <= wr_word;
    end
  end

  // row written marks, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= row_vld_r[row_nxt];
      if (wr_en) begin
        row_vld_r[row_r] <= 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r  <= bsra_pkg::SLOTS_RESET;
      maxrun_r <= bsra_pkg::MAX_RUN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        bsra_pkg::REG_SLOTS_IN_USE: slots_r  <= cfg_wdata;
        bsra_pkg::REG_MAX_RUN:      maxrun_r <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  // request context and run tracking
  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    if (cmd.load) begin
      op_r    <= in_opcode;
      lo_r    <= NW'(in_run_start);
      hi_r    <= NW'(in_run_start) + NW'(in_run_length);
      len_r   <= in_run_length;
      first_r <= '0;
      run_r   <= '0;
    end else if (cmd.scan && stat.found) begin
      first_r <= {row_r, p};
      run_r   <= run_new;
    end else if (cmd.ext) begin
      run_r <= run_new;
    end
  end

  // used and peak counts after the request
  always_comb begin
    used_sum = {1'b0, used_r} + (NW + 1)'(run_r);
    used_add = (used_sum > (NW + 1)'(bsra_pkg::SLOTS)) ? NW'(bsra_pkg::SLOTS)
                                                     : used_sum[NW-1:0];
    used_sub = (used_r > NW'(len_r)) ? (used_r - NW'(len_r)) : '0;
    if (op_r == bsra_pkg::OP_FREE) begin
      used_new = (cmd.status == bsra_pkg::ST_OK) ? used_sub : used_r;
    end else begin
      used_new = used_add;
    end
    peak_new = (used_new > peak_r) ? used_new : peak_r;
  end

  // counters and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      peak_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
      if (cmd.finish) begin
        used_r <= used_new;
        peak_r <= peak_new;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status       <= cmd.status;
      out_grant_start  <= first_r;
      out_grant_length <= run_r;
      out_used_count   <= used_new;
      out_peak_count   <= peak_new;
    end
  end

endmodule

@@ rtl/core/bitmap_slot_run_allocator.sv @@
// top level of the bitmap first-fit slot run allocator
//
//  channel   ports                                            transfer when
//  request   start, busy, in_opcode, in_run_start,            start && !busy
//            in_run_length
//  result    out_valid, out_status, out_grant_start,          out_valid (one cycle)
//            out_grant_length, out_used_count, out_peak_count
//  config    cfg_we, cfg_addr, cfg_wdata                      cfg_we
//
// The bitmap is kept as 16 rows of 16 slots in a memory with one write and one
// registered read port; a request walks it one row per cycle.
// Allocate: the scan walks the rows for the first clear slot, then extends the run
// into the following rows; free: the rows of the range are cleared one by one.
// Synchronous reset clears the row written marks at once, so the bitmap reads
// as all clear with no sweep; counters reset to zero, config to 256 and 16.
// busy stays high from the request transfer until the strobe cycle, so the next
// request can be taken at the edge that ends the strobe; results cannot be
// stalled by the receiver.
module bitmap_slot_run_allocator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_opcode,
  input  logic [bsra_pkg::IDX_W-1:0]         in_run_start,
  input  logic [bsra_pkg::LEN_W-1:0]         in_run_length,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [bsra_pkg::IDX_W-1:0]         out_grant_start,
  output logic [bsra_pkg::LEN_W-1:0]         out_grant_length,
  output logic [bsra_pkg::CNT_W-1:0]         out_used_count,
  output logic [bsra_pkg::CNT_W-1:0]         out_peak_count,
  input  logic                               cfg_we,
  input  logic [bsra_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [bsra_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  bsra_pkg::dp_cmd_t  cmd;
  bsra_pkg::dp_stat_t stat;
  logic               ctrl_busy;

  // sequencer
  bsra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (ctrl_busy)
  );

  // bitmap and counters
  bsra_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_run_start     (in_run_start),
    .in_run_length    (in_run_length),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_grant_start  (out_grant_start),
    .out_grant_length (out_grant_length),
    .out_used_count   (out_used_count),
    .out_peak_count   (out_peak_count)
  );

  // busy drops as the result strobe rises
  assign busy = ctrl_busy;

endmodule

@@ bench/tb_bitmap_slot_run_allocator.sv @@
// self-checking testbench of the bitmap slot run allocator
module tb_bitmap_slot_run_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W      = bsra_pkg::IDX_W;
  localparam int LEN_W      = bsra_pkg::LEN_W;
  localparam int CNT_W      = bsra_pkg::CNT_W;
  localparam int CFG_IDX_W  = bsra_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = bsra_pkg::CFG_DATA_W;
  localparam int SLOTS      = bsra_pkg::SLOTS;
  localparam int RUN_LIMIT  = bsra_pkg::RUN_LIMIT;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 80;

  // one result of the block, field by field
  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] grant_start;
    logic [LEN_W-1:0] grant_length;
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] peak_count;
  } slot_result_t;

  // one line of the directed plan: a request or a register write
  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  op;
    logic [IDX_W-1:0]      first_slot;
    logic [LEN_W-1:0]      count;
    bit                    known;
    slot_result_t          want;
  } plan_row_t;

  // a run handed out by the allocator, kept for later frees
  typedef struct packed {
    logic [IDX_W-1:0] first_slot;
    logic [LEN_W-1:0] count;
  } run_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = bsra_pkg::OP_ALLOC;
  logic [IDX_W-1:0] in_run_start = '0;
  logic [LEN_W-1:0] in_run_length = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [IDX_W-1:0] out_grant_start;
  logic [LEN_W-1:0] out_grant_length;
  logic [CNT_W-1:0] out_used_count;
  logic [CNT_W-1:0] out_peak_count;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow of the page: bitmap, counters and registers
  bit               page_map [SLOTS];
  int unsigned      used_slots_now;
  int unsigned      peak_slots_now;
  logic [CNT_W-1:0] slots_cfg = bsra_pkg::SLOTS_RESET;
  logic [LEN_W-1:0] run_cfg = bsra_pkg::MAX_RUN_RESET;

  slot_result_t pending_results [$];
  run_t         granted_runs [$];
  plan_row_t    plan [$];
  int           mismatches = 0;
  int           cycles = 0;

  bitmap_slot_run_allocator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_run_start     (in_run_start),
    .in_run_length    (in_run_length),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_grant_start  (out_grant_start),
    .out_grant_length (out_grant_length),
    .out_used_count   (out_used_count),
    .out_peak_count   (out_peak_count),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // first-fit allocation and run free on the shadow page
  function automatic slot_result_t compute_grant(logic op, logic [IDX_W-1:0] first_slot,
                                                 logic [LEN_W-1:0] count);
    slot_result_t r;
    int n;
    int lim;
    int first;
    int run;
    r = '0;
    r.status = bsra_pkg::ST_OK;
    n = (slots_cfg > SLOTS) ? SLOTS : int'(slots_cfg);
    if (op == bsra_pkg::OP_ALLOC) begin
      first = 0;
      while (first < n && page_map[first]) first++;
      if (first >= n) begin
        r.status = bsra_pkg::ST_NO_FREE;
      end else begin
        lim = (run_cfg == 0) ? 1 : ((run_cfg > RUN_LIMIT) ? RUN_LIMIT : int'(run_cfg));
        run = 1;
        while (run < lim && first + run < n && !page_map[first + run]) run++;
        for (int i = first; i < first + run; i++) page_map[i] = 1'b1;
        used_slots_now += run;
        if (used_slots_now > SLOTS) used_slots_now = SLOTS;
        if (used_slots_now > peak_slots_now) peak_slots_now = used_slots_now;
        r.grant_start  = first[IDX_W-1:0];
        r.grant_length = run[LEN_W-1:0];
      end
    end else if (int'(first_slot) + int'(count) > n) begin
      r.status = bsra_pkg::ST_RANGE;
    end else begin
      for (int i = int'(first_slot); i < int'(first_slot) + int'(count); i++) page_map[i] = 1'b0;
      used_slots_now = (used_slots_now > count) ? used_slots_now - count : 0;
    end
    r.used_count = used_slots_now[CNT_W-1:0];
    r.peak_count = peak_slots_now[CNT_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t req(logic op, logic [IDX_W-1:0] first_slot,
                                    logic [LEN_W-1:0] count);
    plan_row_t r;
    r = '0;
    r.op = op;
    r.first_slot = first_slot;
    r.count = count;
    return r;
  endfunction

  function automatic plan_row_t req_known(logic op, logic [IDX_W-1:0] first_slot,
                                          logic [LEN_W-1:0] count, logic [1:0] st,
                                          logic [IDX_W-1:0] gs, logic [LEN_W-1:0] gl,
                                          logic [CNT_W-1:0] used, logic [CNT_W-1:0] peak);
    plan_row_t r;
    r = req(op, first_slot, count);
    r.known = 1'b1;
    r.want = '{status: st, grant_start: gs, grant_length: gl, used_count: used,
               peak_count: peak};
    return r;
  endfunction

  function automatic plan_row_t reg_write(logic [CFG_IDX_W-1:0] sel,
                                          logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  // present one request and hold it until the block takes it
  task automatic issue_request(logic op, logic [IDX_W-1:0] first_slot,
                               logic [LEN_W-1:0] count, bit known, slot_result_t want);
    slot_result_t got;
    start <= 1'b1;
    in_opcode <= op;
    in_run_start <= first_slot;
    in_run_length <= count;
    do @(posedge clk); while (busy);
    got = compute_grant(op, first_slot, count);
    if (op == bsra_pkg::OP_ALLOC && got.status == bsra_pkg::ST_OK)
      granted_runs.push_back('{first_slot: got.grant_start, count: got.grant_length});
    pending_results.push_back(known ? want : got);
  endtask

  // stop sending and wait until every result is back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    if (sel == bsra_pkg::REG_SLOTS_IN_USE) slots_cfg = val;
    else run_cfg = val[LEN_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result check against the oldest outstanding expectation
  always @(posedge clk) begin : result_check
    slot_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", CNT_W'(want.status), CNT_W'(out_status));
        check_field("grant_start", CNT_W'(want.grant_start), CNT_W'(out_grant_start));
        check_field("grant_length", CNT_W'(want.grant_length), CNT_W'(out_grant_length));
        check_field("used_count", want.used_count, out_used_count);
        check_field("peak_count", want.peak_count, out_peak_count);
      end
    end
  end

  initial begin
    int phase_slots [PHASES] = '{256, 1, 511, 0, 37, 200, 256, 100};
    int phase_run [PHASES]   = '{16, 1, 127, 5, 0, 64, 3, 40};
    int phase_idle [PHASES]  = '{0, 60, 25, 0, 60, 25, 60, 25};
    logic op;
    logic [IDX_W-1:0] first_slot;
    logic [LEN_W-1:0] count;
    int n_eff;
    int hi;
    int sel;
    int pick;
    int gap;

    // directed plan: fill, free, register extremes, shrink and regrow the page
    plan.push_back(req_known(bsra_pkg::OP_ALLOC, 8'd0, 7'd0,
                             bsra_pkg::ST_OK, 8'd0, 7'd16, 9'd16, 9'd16));
    plan.push_back(req_known(bsra_pkg::OP_ALLOC, 8'hff, 7'h7f,
                             bsra_pkg::ST_OK, 8'd16, 7'd16, 9'd32, 9'd32));
    plan.push_back(req_known(bsra_pkg::OP_FREE, 8'd0, 7'd0,
                             bsra_pkg::ST_OK, 8'd0, 7'd0, 9'd32, 9'd32));
    plan.push_back(req_known(bsra_pkg::OP_FREE, 8'd255, 7'd2,
                             bsra_pkg::ST_RANGE, 8'd0, 7'd0, 9'd32, 9'd32));
    plan.push_back(req_known(bsra_pkg::OP_FREE, 8'd255, 7'd127,
                             bsra_pkg::ST_RANGE, 8'd0, 7'd0, 9'd32, 9'd32));
    plan.push_back(req_known(bsra_pkg::OP_FREE, 8'd8, 7'd4,
                             bsra_pkg::ST_OK, 8'd0, 7'd0, 9'd28, 9'd32));
    plan.push_back(req(bsra_pkg::OP_ALLOC, 8'd0, 7'd0));
    plan.push_back(req_known(bsra_pkg::OP_FREE, 8'd0, 7'd64,
                             bsra_pkg::ST_OK, 8'd0, 7'd0, 9'd0, 9'd32));
    plan.push_back(req_known(bsra_pkg::OP_FREE, 8'd255, 7'd1,
                             bsra_pkg::ST_OK, 8'd0, 7'd0, 9'd0, 9'd32));
    plan.push_back(reg_write(bsra_pkg::REG_MAX_RUN, 9'd127));
    plan.push_back(req_known(bsra_pkg::OP_ALLOC, 8'd0, 7'd0,
                             bsra_pkg::ST_OK, 8'd0, 7'd64, 9'd64, 9'd64));
    plan.push_back(reg_write(bsra_pkg::REG_MAX_RUN, 9'd0));
    plan.push_back(req_known(bsra_pkg::OP_ALLOC, 8'd0, 7'd0,
                             bsra_pkg::ST_OK, 8'd64, 7'd1, 9'd65, 9'd65));
    plan.push_back(reg_write(bsra_pkg::REG_SLOTS_IN_USE, 9'd0));
    plan.push_back(req_known(bsra_pkg::OP_ALLOC, 8'd0, 7'd0,
                             bsra_pkg::ST_NO_FREE, 8'd0, 7'd0, 9'd65, 9'd65));
    plan.push_back(req_known(bsra_pkg::OP_FREE, 8'd0, 7'd0,
                             bsra_pkg::ST_OK, 8'd0, 7'd0, 9'd65, 9'd65));
    plan.push_back(req_known(bsra_pkg::OP_FREE, 8'd0, 7'd1,
                             bsra_pkg::ST_RANGE, 8'd0, 7'd0, 9'd65, 9'd65));
    plan.push_back(reg_write(bsra_pkg::REG_SLOTS_IN_USE, 9'd511));
    plan.push_back(reg_write(bsra_pkg::REG_MAX_RUN, 9'd64));
    plan.push_back(req_known(bsra_pkg::OP_ALLOC, 8'd0, 7'd0,
                             bsra_pkg::ST_OK, 8'd65, 7'd64, 9'd129, 9'd129));
    plan.push_back(req_known(bsra_pkg::OP_ALLOC, 8'd0, 7'd0,
                             bsra_pkg::ST_OK, 8'd129, 7'd64, 9'd193, 9'd193));
    plan.push_back(req_known(bsra_pkg::OP_ALLOC, 8'd0, 7'd0,
                             bsra_pkg::ST_OK, 8'd193, 7'd63, 9'd256, 9'd256));
    plan.push_back(req_known(bsra_pkg::OP_ALLOC, 8'd0, 7'd0,
                             bsra_pkg::ST_NO_FREE, 8'd0, 7'd0, 9'd256, 9'd256));
    plan.push_back(req_known(bsra_pkg::OP_FREE, 8'd200, 7'd10,
                             bsra_pkg::ST_OK, 8'd0, 7'd0, 9'd246, 9'd256));
    plan.push_back(reg_write(bsra_pkg::REG_SLOTS_IN_USE, 9'd100));
    plan.push_back(req_known(bsra_pkg::OP_ALLOC, 8'd0, 7'd0,
                             bsra_pkg::ST_NO_FREE, 8'd0, 7'd0, 9'd246, 9'd256));
    plan.push_back(req(bsra_pkg::OP_FREE, 8'd90, 7'd10));
    plan.push_back(req_known(bsra_pkg::OP_FREE, 8'd95, 7'd6,
                             bsra_pkg::ST_RANGE, 8'd0, 7'd0, 9'd236, 9'd256));
    plan.push_back(req(bsra_pkg::OP_ALLOC, 8'd0, 7'd0));
    plan.push_back(reg_write(bsra_pkg::REG_SLOTS_IN_USE, 9'd1));
    plan.push_back(reg_write(bsra_pkg::REG_MAX_RUN, 9'd1));
    plan.push_back(req(bsra_pkg::OP_FREE, 8'd0, 7'd1));
    plan.push_back(req(bsra_pkg::OP_ALLOC, 8'd0, 7'd0));
    plan.push_back(req_known(bsra_pkg::OP_ALLOC, 8'd0, 7'd0,
                             bsra_pkg::ST_NO_FREE, 8'd0, 7'd0, 9'd246, 9'd256));
    plan.push_back(reg_write(bsra_pkg::REG_SLOTS_IN_USE, 9'd256));
    plan.push_back(reg_write(bsra_pkg::REG_MAX_RUN, 9'd16));
    // slots kept above the old limit come back into use
    plan.push_back(req(bsra_pkg::OP_ALLOC, 8'd0, 7'd0));

    // reset
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        write_reg(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        issue_request(plan[i].op, plan[i].first_slot, plan[i].count, plan[i].known,
                      plan[i].want);
      end
    end

    // random phases, each with its own page size, run limit and idle rate
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_reg(bsra_pkg::REG_SLOTS_IN_USE, phase_slots[ph][CFG_DATA_W-1:0]);
      write_reg(bsra_pkg::REG_MAX_RUN, phase_run[ph][CFG_DATA_W-1:0]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        n_eff = (slots_cfg > SLOTS) ? SLOTS : int'(slots_cfg);
        sel = $urandom_range(99);
        op = bsra_pkg::OP_FREE;
        first_slot = IDX_W'($urandom);
        count = LEN_W'($urandom);
        if (sel < 50) begin
          op = bsra_pkg::OP_ALLOC;
        end else if (sel < 75 && granted_runs.size() != 0) begin
          // give back a run that was handed out earlier
          pick = $urandom_range(granted_runs.size() - 1);
          first_slot = granted_runs[pick].first_slot;
          count = granted_runs[pick].count;
          granted_runs.delete(pick);
        end else if (sel < 90 && n_eff > 0) begin
          // free a random in-range run
          first_slot = IDX_W'($urandom_range(n_eff - 1));
          hi = n_eff - int'(first_slot);
          if (hi > RUN_LIMIT) hi = RUN_LIMIT;
          count = LEN_W'($urandom_range(hi));
        end
        gap = ($urandom_range(99) < phase_idle[ph]) ? $urandom_range(1, 24) : 0;
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        issue_request(op, first_slot, count, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
